[sv/swr_pkg.sv]
`default_nettype none

package swr_pkg;

    // Stream and configuration widths
    localparam int unsigned TDATA_IN_W  = 176;
    localparam int unsigned TDATA_OUT_W = 40;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Headers declaring a longer payload fail their check
    localparam logic [15:0] C_MAX_PAYLOAD_BYTES = 16'd2048;

    localparam logic [15:0] FLAG_SYN = 16'h0001;
    localparam logic [15:0] FLAG_ACK = 16'h0002;
    localparam logic [15:0] FLAG_FIN = 16'h0004;

    localparam logic [31:0] RST_LOCAL_ADDR  = 32'h7F00_0001;
    localparam logic [31:0] RST_REMOTE_ADDR = 32'h7F00_0001;
    localparam logic [15:0] RST_LOCAL_PORT  = 16'd7998;
    localparam logic [15:0] RST_REMOTE_PORT = 16'd7999;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOCAL_ADDR  = 2'd0,
        REG_REMOTE_ADDR = 2'd1,
        REG_LOCAL_PORT  = 2'd2,
        REG_REMOTE_PORT = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_OPEN   = 2'd1,
        PH_CLOSED = 2'd2
    } t_phase;

    // Beat after the header-sum stage
    typedef struct packed {
        logic        hdr;
        logic        last;
        logic [15:0] flags;
        logic [15:0] seq;
        logic [15:0] chk;
        logic [15:0] word;
        logic [15:0] hsum;
        logic        oversize;
    } t_pre;

    // ACK result payload
    typedef struct packed {
        logic [15:0] ack_seq;
        logic [15:0] ack_checksum;
        logic        checksum_ok;
        logic        accepted;
        t_phase      link_status;
    } t_ack;

    // 16-bit ones'-complement add, end-around carry
    function automatic logic [15:0] f_ea_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

    // Fold a wide plain sum of 16-bit terms to its ones'-complement value
    function automatic logic [15:0] f_fold20(input logic [19:0] s);
        return f_ea_add(s[15:0], {12'd0, s[19:16]});
    endfunction

endpackage

`default_nettype wire

[sv/swr_hdr_sum.sv]
`default_nettype none

module swr_hdr_sum (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [swr_pkg::TDATA_IN_W-1:0]  i_tdata,
    input  wire logic                            i_payload,
    input  wire logic                            i_last,
    output logic                                 o_valid,
    output swr_pkg::t_pre                        o_pre
);
    import swr_pkg::*;

    logic [15:0] w_flags, w_sport, w_dport, w_seq, w_chk, w_word;
    logic [31:0] w_src, w_dst;
    logic [11:0] w_len;
    logic [19:0] w_sum;
    logic        r_valid;
    t_pre        r_pre;
    t_pre        n_pre;

    assign w_flags = i_tdata[15:0];
    assign w_src   = i_tdata[47:16];
    assign w_dst   = i_tdata[79:48];
    assign w_sport = i_tdata[95:80];
    assign w_dport = i_tdata[111:96];
    assign w_seq   = i_tdata[127:112];
    assign w_len   = i_tdata[139:128];
    assign w_chk   = i_tdata[155:140];
    assign w_word  = i_tdata[171:156];

    // plain sum of the nine header terms, folded once at the end
    assign w_sum = {4'd0, w_flags} + {4'd0, w_src[31:16]} + {4'd0, w_src[15:0]}
                 + {4'd0, w_dst[31:16]} + {4'd0, w_dst[15:0]} + {4'd0, w_sport}
                 + {4'd0, w_dport} + {4'd0, w_seq} + {8'd0, w_len};

    always_comb begin
        n_pre.hdr      = ~i_payload;
        n_pre.last     = i_last;
        n_pre.flags    = w_flags;
        n_pre.seq      = w_seq;
        n_pre.chk      = w_chk;
        n_pre.word     = w_word;
        n_pre.hsum     = f_fold20(w_sum);
        n_pre.oversize = {4'd0, w_len} > C_MAX_PAYLOAD_BYTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_pre <= n_pre;
        end
    end

    assign o_valid = r_valid;
    assign o_pre   = r_pre;

endmodule

`default_nettype wire

[sv/swr_link_ctrl.sv]
`default_nettype none

module swr_link_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire swr_pkg::t_pre i_pre,
    input  wire logic [15:0]   i_ack_base,
    output logic               o_valid,
    output swr_pkg::t_ack      o_ack
);
    import swr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_exp, n_exp;
    logic [15:0] r_run, n_run;
    logic [15:0] r_flags, r_seq, r_chk;
    logic        r_over;
    logic        r_valid, n_res;
    t_ack        r_ack;

    logic        w_step, w_end, w_ok, w_good, w_over, w_acc;
    logic [15:0] w_flags, w_seq, w_chk, w_sum, w_seq_p1;

    assign w_step = i_en && i_valid;
    assign w_end  = w_step && i_pre.last;

    // header beats use their own fields, payload beats the held ones
    assign w_flags  = i_pre.hdr ? i_pre.flags    : r_flags;
    assign w_seq    = i_pre.hdr ? i_pre.seq      : r_seq;
    assign w_chk    = i_pre.hdr ? i_pre.chk      : r_chk;
    assign w_over   = i_pre.hdr ? i_pre.oversize : r_over;
    assign w_sum    = i_pre.hdr ? i_pre.hsum     : f_ea_add(r_run, i_pre.word);
    assign w_ok     = !w_over && (({1'b0, w_chk} + {1'b0, w_sum}) == 17'h0ffff);
    assign w_good   = w_ok && (w_seq == r_exp);
    assign w_seq_p1 = w_seq + 16'd1;

    assign n_run = i_pre.last ? 16'd0 : w_sum;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_exp   = r_exp;
        if (w_end) begin
            case (r_phase)
                PH_WAIT: begin
                    if (w_flags == FLAG_SYN) begin
                        n_phase = PH_OPEN;
                        n_exp   = w_seq_p1;
                    end
                end
                PH_OPEN: begin
                    if (w_good) begin
                        n_exp = w_seq_p1;
                        if (w_flags == FLAG_FIN) begin
                            n_phase = PH_CLOSED;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        n_res = 1'b0;
        w_acc = 1'b0;
        if (w_end) begin
            case (r_phase)
                PH_WAIT: begin
                    n_res = (w_flags == FLAG_SYN);
                    w_acc = (w_flags == FLAG_SYN);
                end
                PH_OPEN: begin
                    n_res = 1'b1;
                    w_acc = w_good;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_exp   <= 16'd0;
            r_run   <= 16'd0;
            r_flags <= 16'd0;
            r_seq   <= 16'd0;
            r_chk   <= 16'd0;
            r_over  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_res;
            if (w_step) begin
                r_phase <= n_phase;
                r_exp   <= n_exp;
                r_run   <= n_run;
                r_flags <= w_flags;
                r_seq   <= w_seq;
                r_chk   <= w_chk;
                r_over  <= w_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && n_res) begin
            r_ack.ack_seq      <= n_exp;
            r_ack.ack_checksum <= ~f_ea_add(i_ack_base, n_exp);
            r_ack.checksum_ok  <= w_ok;
            r_ack.accepted     <= w_acc;
            r_ack.link_status  <= n_phase;
        end
    end

    assign o_valid = r_valid;
    assign o_ack   = r_ack;

endmodule

`default_nettype wire

[sv/stop_and_wait_receiver_checksum.sv]
// Stop-and-wait receiver with 16-bit ones'-complement checksum. Packets arrive
// on the slave stream as one header beat (tuser 0) followed by payload-word
// beats (tuser 1); tlast marks the final beat of a packet. The block sums the
// header fields and payload words with end-around carry, checks the sum
// against the carried checksum on the last beat, runs the connection state
// (waiting for SYN, open, closed after FIN) and emits at most one ACK result
// per packet on the master stream, including the ACK header checksum built
// from the configured addresses and ports. One beat is taken every cycle
// while the result register is free or being drained; a packet's result is
// registered through the header-sum stage, then the state stage that owns the
// running sum and sequence number. Configuration registers are written through
// a plain write port, by the user only while no packet is in flight (the block
// does not enforce this); a write applies to every beat accepted after it.
`default_nettype none

module stop_and_wait_receiver_checksum (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream, tdata from bit 0: hdr_flags[15:0], hdr_src_addr[31:0],
    // hdr_dst_addr[31:0], hdr_src_port[15:0], hdr_dst_port[15:0],
    // hdr_seq[15:0], hdr_length[11:0], hdr_checksum[15:0], payload_word[15:0],
    // zero pad to 176 bits
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [swr_pkg::TDATA_IN_W-1:0]  i_s_axis_tdata,
    input  wire logic                            i_s_axis_tuser,   // req_type
    input  wire logic                            i_s_axis_tlast,   // last_item
    // master stream, tdata from bit 0: ack_valid, ack_seq[15:0],
    // ack_checksum[15:0], checksum_ok, accepted, link_status[1:0],
    // zero pad to 40 bits
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [swr_pkg::TDATA_OUT_W-1:0]      o_m_axis_tdata,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [swr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [swr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import swr_pkg::*;

    // configuration
    logic [31:0] r_local_addr, r_remote_addr;
    logic [15:0] r_local_port, r_remote_port;
    // constant part of the ACK header sum (flags ACK, addresses, ports)
    logic [15:0] r_ack_base;
    logic [19:0] w_base_sum;

    logic  w_en;
    logic  w_pre_valid;
    t_pre  w_pre;
    logic  w_res_valid;
    t_ack  w_ack;

    // whole pipeline moves when the result register is empty or draining
    assign w_en            = !w_res_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= RST_LOCAL_ADDR;
            r_remote_addr <= RST_REMOTE_ADDR;
            r_local_port  <= RST_LOCAL_PORT;
            r_remote_port <= RST_REMOTE_PORT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_LOCAL_ADDR:  r_local_addr  <= i_cfg_wdata;
                REG_REMOTE_ADDR: r_remote_addr <= i_cfg_wdata;
                REG_LOCAL_PORT:  r_local_port  <= i_cfg_wdata[15:0];
                REG_REMOTE_PORT: r_remote_port <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_base_sum = {4'd0, FLAG_ACK}
                      + {4'd0, r_local_addr[31:16]}  + {4'd0, r_local_addr[15:0]}
                      + {4'd0, r_remote_addr[31:16]} + {4'd0, r_remote_addr[15:0]}
                      + {4'd0, r_local_port} + {4'd0, r_remote_port};

    // refreshed every cycle; settles in the cycle after a config write
    always_ff @(posedge i_clk) begin
        r_ack_base <= f_fold20(w_base_sum);
    end

    swr_hdr_sum u_hdr_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_tdata   (i_s_axis_tdata),
        .i_payload (i_s_axis_tuser),
        .i_last    (i_s_axis_tlast),
        .o_valid   (w_pre_valid),
        .o_pre     (w_pre)
    );

    swr_link_ctrl u_link_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_pre_valid),
        .i_pre      (w_pre),
        .i_ack_base (r_ack_base),
        .o_valid    (w_res_valid),
        .o_ack      (w_ack)
    );

    assign o_m_axis_tvalid = w_res_valid;
    assign o_m_axis_tdata  = {3'd0, w_ack.link_status, w_ack.accepted, w_ack.checksum_ok,
                              w_ack.ack_checksum, w_ack.ack_seq, 1'b1};

endmodule

`default_nettype wire

[sv/swr_checker.sv]
`default_nettype none

module swr_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_s_axis_tready,
    input  wire logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic [swr_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata
);
    import swr_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result beat changed while stalled");

    // nothing comes out straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat after reset");

    // a rejected packet is only ever answered on an open link
    a_nak_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[34]) |-> (o_m_axis_tdata[36:35] == 2'(PH_OPEN)))
        else $error("non-accepted ACK outside open link");

    // an accepted packet never leaves the link waiting
    a_acc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[34]) |->
            (o_m_axis_tdata[36:35] == 2'(PH_OPEN) || o_m_axis_tdata[36:35] == 2'(PH_CLOSED)))
        else $error("accepted ACK with bad link status");

    // input stalls only behind a full, stalled result register
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready && o_m_axis_tdata[0]))
        else $error("input stalled without output back-pressure");

endmodule

bind stop_and_wait_receiver_checksum swr_checker u_swr_checker (.*);

`default_nettype wire

[verif/stop_and_wait_receiver_checksum_tb.sv]
`default_nettype none

module stop_and_wait_receiver_checksum_tb;
    import swr_pkg::*;

    // One input beat as the predictor sees it
    typedef struct packed {
        logic        req;        // 0 header, 1 payload word
        logic [15:0] flags;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] seq;
        logic [11:0] length;
        logic [15:0] chk;
        logic [15:0] word;
        logic        last;
    } rx_beat_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    wire logic               o_s_axis_tready;
    logic [TDATA_IN_W-1:0]   i_s_axis_tdata = '0;
    logic                    i_s_axis_tuser = 1'b0;
    logic                    i_s_axis_tlast = 1'b0;
    wire logic               o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    wire logic [TDATA_OUT_W-1:0] o_m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = REG_LOCAL_ADDR;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    stop_and_wait_receiver_checksum dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor copy of the ACK header registers
    logic [31:0] cfg_local_addr  = RST_LOCAL_ADDR;
    logic [31:0] cfg_remote_addr = RST_REMOTE_ADDR;
    logic [15:0] cfg_local_port  = RST_LOCAL_PORT;
    logic [15:0] cfg_remote_port = RST_REMOTE_PORT;

    // Predictor copy of the link state
    t_phase      rx_phase = PH_WAIT;
    logic [15:0] next_seq = '0;
    logic [15:0] run_sum = '0;
    logic [15:0] hold_flags = '0;
    logic [15:0] hold_seq = '0;
    logic [15:0] hold_chk = '0;
    logic        hold_oversize = 1'b0;

    t_ack        acks_due[$];     // ACKs owed, oldest first
    logic [15:0] pkt_words[$];    // payload of the packet being built
    int          errors = 0;
    int          send_idle_pct = 14;
    int          recv_idle_pct = 85;
    logic        holding = 1'b0;  // receiver hold-off in progress

    // 16-bit ones'-complement add, end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = 17'(a) + 17'(b);
        if (s >= 17'h10000)
            s = s - 17'h0ffff;
        return s[15:0];
    endfunction

    function automatic logic [15:0] oc_add32(input logic [15:0] acc, input logic [31:0] v);
        return oc_add(oc_add(acc, v[31:16]), v[15:0]);
    endfunction

    // Sum over the header fields, carried checksum excluded
    function automatic logic [15:0] header_sum(input rx_beat_t b);
        logic [15:0] s;
        s = oc_add(16'h0000, b.flags);
        s = oc_add32(s, b.src_addr);
        s = oc_add32(s, b.dst_addr);
        s = oc_add(s, b.src_port);
        s = oc_add(s, b.dst_port);
        s = oc_add(s, b.seq);
        return oc_add(s, {4'h0, b.length});
    endfunction

    function automatic logic [15:0] ack_header_checksum(input logic [15:0] seq);
        logic [15:0] s;
        s = oc_add(16'h0000, FLAG_ACK);
        s = oc_add32(s, cfg_local_addr);
        s = oc_add32(s, cfg_remote_addr);
        s = oc_add(s, cfg_local_port);
        s = oc_add(s, cfg_remote_port);
        s = oc_add(s, seq);
        s = oc_add(s, 16'h0000);
        return ~s;
    endfunction

    // Advance the link state by one accepted beat; queue the ACK it owes, if any
    function automatic void track_beat(input rx_beat_t b);
        logic ok;
        logic adv;
        t_ack a;
        adv = 1'b0;
        if (!b.req) begin
            hold_flags    = b.flags;
            hold_seq      = b.seq;
            hold_chk      = b.chk;
            hold_oversize = 16'(b.length) > C_MAX_PAYLOAD_BYTES;
            run_sum       = header_sum(b);
        end else begin
            run_sum = oc_add(run_sum, b.word);
        end
        if (!b.last)
            return;
        ok = !hold_oversize && ((17'(hold_chk) + 17'(run_sum)) == 17'h0ffff);
        run_sum = '0;
        case (rx_phase)
            PH_WAIT: begin
                // only an exact SYN opens the link, its sum is not required
                if (hold_flags != FLAG_SYN)
                    return;
                next_seq = hold_seq + 16'd1;
                rx_phase = PH_OPEN;
                adv = 1'b1;
            end
            PH_OPEN: begin
                if (ok && hold_seq == next_seq) begin
                    next_seq = hold_seq + 16'd1;
                    adv = 1'b1;
                    if (hold_flags == FLAG_FIN)
                        rx_phase = PH_CLOSED;
                end
            end
            default: return;    // closed: everything ignored
        endcase
        a.ack_seq      = next_seq;
        a.ack_checksum = ack_header_checksum(next_seq);
        a.checksum_ok  = ok;
        a.accepted     = adv;
        a.link_status  = rx_phase;
        acks_due.push_back(a);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", msg);
    endtask

    // Random beat; an exact FIN is kept out so the link only closes on purpose
    function automatic rx_beat_t random_beat();
        rx_beat_t b;
        b.req      = 1'b0;
        b.flags    = 16'($urandom);
        b.src_addr = $urandom;
        b.dst_addr = $urandom;
        b.src_port = 16'($urandom);
        b.dst_port = 16'($urandom);
        b.seq      = 16'($urandom);
        b.length   = 12'($urandom_range(2048));
        b.chk      = 16'($urandom);
        b.word     = 16'($urandom);
        b.last     = 1'b0;
        if (b.flags == FLAG_FIN)
            b.flags = FLAG_FIN | FLAG_ACK;
        return b;
    endfunction

    function automatic rx_beat_t make_header(input logic [15:0] flags, input logic [15:0] seq,
                                             input logic [11:0] len);
        rx_beat_t b;
        b = random_beat();
        b.flags  = flags;
        b.seq    = seq;
        b.length = len;
        return b;
    endfunction

    // Offer one beat, with random idle cycles first; returns at the accepting edge
    task automatic send_beat(input rx_beat_t b);
        logic [TDATA_IN_W-1:0] d;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        d = '0;
        d[15:0]    = b.flags;
        d[47:16]   = b.src_addr;
        d[79:48]   = b.dst_addr;
        d[95:80]   = b.src_port;
        d[111:96]  = b.dst_port;
        d[127:112] = b.seq;
        d[139:128] = b.length;
        d[155:140] = b.chk;
        d[171:156] = b.word;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= b.req;
        i_s_axis_tlast  <= b.last;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        track_beat(b);
    endtask

    // Header plus pkt_words; checksum set right or deliberately wrong
    task automatic send_packet(input rx_beat_t hb, input logic good_sum);
        logic [15:0] s;
        rx_beat_t pb;
        s = header_sum(hb);
        foreach (pkt_words[i])
            s = oc_add(s, pkt_words[i]);
        hb.chk = 16'hffff - s;
        if (!good_sum)
            hb.chk = hb.chk ^ 16'($urandom_range(65535, 1));
        hb.req  = 1'b0;
        hb.last = (pkt_words.size() == 0);
        send_beat(hb);
        foreach (pkt_words[i]) begin
            pb      = random_beat();
            pb.req  = 1'b1;
            pb.word = pkt_words[i];
            pb.last = (i == pkt_words.size() - 1);
            send_beat(pb);
        end
    endtask

    // Stop offering, wait for every owed ACK, then let the pipeline settle
    task automatic wait_drain(input int bound);
        int n;
        n = 0;
        i_s_axis_tvalid <= 1'b0;
        while (acks_due.size() != 0 && n < bound) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    // All four registers back to back, only with the block idle
    task automatic apply_settings(input logic [31:0] la, input logic [31:0] ra,
                                  input logic [15:0] lp, input logic [15:0] rp);
        wait_drain(20000);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_LOCAL_ADDR;
        i_cfg_wdata <= la;
        @(posedge i_clk);
        i_cfg_addr  <= REG_REMOTE_ADDR;
        i_cfg_wdata <= ra;
        @(posedge i_clk);
        i_cfg_addr  <= REG_LOCAL_PORT;
        i_cfg_wdata <= {16'h0000, lp};
        @(posedge i_clk);
        i_cfg_addr  <= REG_REMOTE_PORT;
        i_cfg_wdata <= {16'h0000, rp};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_local_addr  = la;
        cfg_remote_addr = ra;
        cfg_local_port  = lp;
        cfg_remote_port = rp;
        @(posedge i_clk);
    endtask

    // Waiting for SYN: nothing but an exact SYN gets an answer
    task automatic test_waiting_phase();
        rx_beat_t b;
        // payload word with no header before it
        b = random_beat();
        b.req  = 1'b1;
        b.word = 16'hffff;
        b.last = 1'b1;
        send_beat(b);
        pkt_words.delete();
        send_packet(make_header(FLAG_ACK, 16'h0000, 12'd0), 1'b1);
        send_packet(make_header(FLAG_SYN | FLAG_FIN, 16'h1234, 12'd0), 1'b1);
        pkt_words = '{16'hffff, 16'h0000};
        send_packet(make_header(16'hffff, 16'h0001, 12'd4), 1'b1);
        // SYN opens even with a bad sum and an oversize length; seq wraps to zero
        b = make_header(FLAG_SYN, 16'hffff, 12'hfff);
        b.src_addr = '1;
        b.dst_addr = '1;
        b.src_port = '1;
        b.dst_port = '1;
        pkt_words.delete();
        send_packet(b, 1'b0);
    endtask

    // Open link: good, damaged and out-of-order packets, field extremes
    task automatic test_open_link();
        rx_beat_t b;
        b = make_header(16'h0000, next_seq, 12'd0);
        b.src_addr = '0;
        b.dst_addr = '0;
        b.src_port = '0;
        b.dst_port = '0;
        pkt_words.delete();
        send_packet(b, 1'b1);
        // odd length, tail byte padded
        pkt_words = '{16'hffff, 16'h0000, 16'hff00};
        send_packet(make_header(16'hffff, next_seq, 12'd5), 1'b1);
        pkt_words.delete();
        send_packet(make_header(FLAG_ACK, next_seq, 12'd0), 1'b0);
        send_packet(make_header(FLAG_ACK, next_seq ^ 16'h8000, 12'd0), 1'b1);
        send_packet(make_header(FLAG_ACK, next_seq, 12'd2049), 1'b1);
        // SYN inside an open link is plain data; length at its ceiling
        pkt_words = '{16'($urandom)};
        send_packet(make_header(FLAG_SYN, next_seq, 12'd2048), 1'b1);
        // FIN that fails its check must not close
        pkt_words.delete();
        send_packet(make_header(FLAG_FIN, next_seq, 12'd0), 1'b0);
        // FIN with another flag set is not a close
        send_packet(make_header(FLAG_FIN | FLAG_ACK, next_seq, 12'd0), 1'b1);
        // stray word after the packet ended: summed on its own
        b = random_beat();
        b.req  = 1'b1;
        b.last = 1'b1;
        send_beat(b);
        // header cut short by a fresh header
        b = make_header(FLAG_ACK, next_seq, 12'd10);
        send_beat(b);
        pkt_words = '{16'($urandom)};
        send_packet(make_header(FLAG_ACK, next_seq, 12'd2), 1'b1);
    endtask

    // Mostly well-formed packets in order, with damaged and broken ones mixed in
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
        int sent;
        int roll;
        int nw;
        rx_beat_t b;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        sent = 0;
        while (sent < target) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                // payload words with no header
                nw = $urandom_range(3, 1);
                for (int i = 0; i < nw; i++) begin
                    b = random_beat();
                    b.req  = 1'b1;
                    b.last = (i == nw - 1);
                    send_beat(b);
                end
                sent += nw;
                continue;
            end
            b = random_beat();
            b.seq = next_seq;
            if (roll < 11) begin
                // truncated: the next header restarts the sum
                send_beat(b);
                sent++;
                continue;
            end
            nw = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(40, 5);
            pkt_words.delete();
            for (int i = 0; i < nw; i++)
                pkt_words.push_back(16'($urandom));
            b.length = 12'(2 * nw);
            if (nw > 0 && $urandom_range(1) == 1) begin
                b.length = 12'(2 * nw - 1);
                pkt_words[nw - 1][7:0] = 8'h00;
            end
            if (roll < 19)
                b.seq = next_seq + 16'($urandom_range(65535, 1));
            else if (roll < 24)
                b.length = 12'($urandom_range(4095, 2049));
            send_packet(b, !(roll >= 24 && roll < 32));
            sent += nw + 1;
        end
    endtask

    // Receiver holds off for a long stretch while single-beat packets keep coming
    task automatic test_backpressure();
        apply_settings(32'h0000_0000, 32'hffff_ffff, 16'hffff, 16'h0000);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        holding <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                holding <= 1'b0;
            end
        join_none
        pkt_words.delete();
        repeat (40)
            send_packet(make_header(16'($urandom_range(3)), next_seq, 12'd0), 1'b1);
    endtask

    // Good FIN closes the link; anything after it is ignored
    task automatic test_link_close();
        rx_beat_t b;
        pkt_words.delete();
        send_packet(make_header(FLAG_FIN, next_seq, 12'd0), 1'b1);
        send_packet(make_header(FLAG_SYN, next_seq, 12'd0), 1'b1);
        send_packet(make_header(FLAG_ACK, next_seq, 12'd0), 1'b1);
        b = random_beat();
        b.req  = 1'b1;
        b.last = 1'b1;
        send_beat(b);
    endtask

    // Receiver readiness: random per idle setting, forced low during hold-off
    always @(posedge i_clk)
        i_m_axis_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);

    // Every ACK beat against the oldest owed ACK
    // tdata from bit 0: ack_valid, ack_seq, ack_checksum, checksum_ok, accepted, link_status
    always @(posedge i_clk) begin : ack_check
        t_ack want;
        logic [TDATA_OUT_W-1:0] d;
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            d = o_m_axis_tdata;
            if (acks_due.size() == 0) begin
                report_error($sformatf("ACK beat with none owed, seq 0x%h", d[16:1]));
            end else begin
                want = acks_due.pop_front();
                if (d[0] !== 1'b1)
                    report_error($sformatf("ack_valid %b", d[0]));
                if (d[16:1] !== want.ack_seq)
                    report_error($sformatf("ack_seq 0x%h, want 0x%h", d[16:1], want.ack_seq));
                if (d[32:17] !== want.ack_checksum)
                    report_error($sformatf("ack_checksum 0x%h, want 0x%h",
                                           d[32:17], want.ack_checksum));
                if (d[33] !== want.checksum_ok)
                    report_error($sformatf("checksum_ok %b, want %b", d[33], want.checksum_ok));
                if (d[34] !== want.accepted)
                    report_error($sformatf("accepted %b, want %b", d[34], want.accepted));
                if (d[36:35] !== want.link_status)
                    report_error($sformatf("link_status %0d, want %0d",
                                           d[36:35], want.link_status));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_waiting_phase();
        test_open_link();
        apply_settings(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000);
        test_random_traffic(14, 85, 450);
        apply_settings(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
        test_random_traffic(85, 14, 450);
        apply_settings($urandom, $urandom, 16'($urandom), 16'($urandom));
        test_random_traffic(0, 0, 450);
        test_backpressure();
        test_link_close();
        wait_drain(20000);
        if (acks_due.size() != 0)
            report_error($sformatf("%0d ACKs never arrived", acks_due.size()));
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[stop_and_wait_receiver_checksum.f]
sv/swr_pkg.sv
sv/swr_hdr_sum.sv
sv/swr_link_ctrl.sv
sv/stop_and_wait_receiver_checksum.sv
sv/swr_checker.sv
verif/stop_and_wait_receiver_checksum_tb.sv
